/* hdl/mrhm_pkg.sv */
// ----------------------------------------------------------------------------
// mrhm_pkg
// Shared types, codes and the CRC-16 byte step for the read-holding master.
// ----------------------------------------------------------------------------
package mrhm_pkg;

    typedef enum logic {
        OP_REQUEST  = 1'b0,
        OP_RESPONSE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_FRAME  = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED     = 2'd0,
        ST_TOO_SHORT    = 2'd1,
        ST_BAD_FUNCTION = 2'd2,
        ST_SHORT_DATA   = 2'd3
    } status_t;

    // Byte positions within the 8-byte request frame
    typedef enum logic [2:0] {
        FB_SLAVE   = 3'd0,
        FB_FUNC    = 3'd1,
        FB_ADDR_HI = 3'd2,
        FB_ADDR_LO = 3'd3,
        FB_CNT_HI  = 3'd4,
        FB_CNT_LO  = 3'd5,
        FB_CRC_LO  = 3'd6,
        FB_CRC_HI  = 3'd7
    } frame_pos_t;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam int unsigned MIN_RESP_BYTES    = 5;

    // One byte of reflected CRC-16, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/modbus_read_holding_master_core.sv */
// ----------------------------------------------------------------------------
// modbus_read_holding_master_core
// Modbus RTU master, function 3: request framing and response parsing.
// ----------------------------------------------------------------------------
// A request transfer (tuser = 0) yields the 8-byte request frame, one byte a
// cycle while the sink is ready, CRC-16 low byte first; the next input is
// taken in the cycle its last byte moves to the output register. A response
// byte transfer (tuser = 1) yields nothing, a register word, a status, or a
// word then a status. With the sink always ready, response bytes stream at
// one per cycle, but for a byte that yields both a word and a status. The CRC
// is folded in one byte per frame byte handed to the output register by the
// frame sequencer, which sets the request rate. The response CRC is not
// checked; bytes past MAX_RESPONSE_BYTES are dropped uncounted.
module modbus_read_holding_master_core #(
    parameter int unsigned MAX_RESPONSE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] slave_address, [23:8] register_address, [30:24] register_count,
    // [38:31] response_byte, [39] zero
    input  logic [39:0] s_tdata,
    // [0] operation
    input  logic [0:0]  s_tuser,
    // response_end
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_byte, [23:8] register_value, [30:24] register_index,
    // [32:31] status, [39:33] zero
    output logic [39:0] m_tdata,
    // [1:0] kind
    output logic [1:0]  m_tuser,
    // last
    output logic        m_tlast
);
    import mrhm_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam int unsigned CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_RESPONSE_BYTES);

    // input fields
    logic [7:0]  in_slave;
    logic [15:0] in_addr;
    logic [6:0]  in_count;
    logic [7:0]  in_byte;
    op_t         in_op;

    assign in_slave = s_tdata[7:0];
    assign in_addr  = s_tdata[23:8];
    assign in_count = s_tdata[30:24];
    assign in_byte  = s_tdata[38:31];
    assign in_op    = op_t'(s_tuser[0]);

    // parser state
    logic [6:0]       req_count_reg,  req_count_next;
    logic [POS_W-1:0] byte_pos_reg,   byte_pos_next;
    logic [7:0]       func_seen_reg,  func_seen_next;
    logic [7:0]       decl_count_reg, decl_count_next;
    logic [7:0]       pend_high_reg,  pend_high_next;
    logic [6:0]       words_reg,      words_next;

    // work register: the item whose results are being handed out
    logic        work_valid_reg, work_valid_next;
    op_t         work_op_reg,    work_op_next;
    frame_pos_t  work_pos_reg,   work_pos_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  work_slave_reg, work_slave_next;
    logic [15:0] work_addr_reg,  work_addr_next;
    logic [6:0]  work_cnt_reg,   work_cnt_next;
    logic        has_word_reg,   has_word_next;
    logic        has_stat_reg,   has_stat_next;
    logic [15:0] word_val_reg,   word_val_next;
    logic [6:0]  word_idx_reg,   word_idx_next;
    status_t     stat_reg,       stat_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg,  m_data_next;
    kind_t       m_kind_reg,  m_kind_next;
    logic        m_last_reg,  m_last_next;

    // current result of the work register
    kind_t       cur_kind;
    logic [7:0]  cur_frame;
    logic [15:0] cur_value;
    logic [6:0]  cur_index;
    status_t     cur_status;
    logic        cur_last;

    logic out_load;
    logic accept;

    // parser outputs for an accepted response byte
    logic        rsp_word;
    logic        rsp_end;
    logic [15:0] rsp_value;
    status_t     rsp_status;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] need_cmp;

    always_comb begin
        cur_kind   = KIND_FRAME;
        cur_frame  = 8'h00;
        cur_value  = 16'h0000;
        cur_index  = 7'd0;
        cur_status = ST_ACCEPTED;
        cur_last   = 1'b0;
        if (work_op_reg == OP_REQUEST) begin
            cur_kind = KIND_FRAME;
            case (work_pos_reg)
                FB_SLAVE:   cur_frame = work_slave_reg;
                FB_FUNC:    cur_frame = FUNC_READ_HOLDING;
                FB_ADDR_HI: cur_frame = work_addr_reg[15:8];
                FB_ADDR_LO: cur_frame = work_addr_reg[7:0];
                FB_CNT_HI:  cur_frame = 8'h00;
                FB_CNT_LO:  cur_frame = {1'b0, work_cnt_reg};
                FB_CRC_LO:  cur_frame = crc_reg[7:0];
                FB_CRC_HI:  cur_frame = crc_reg[15:8];
                default:    cur_frame = 8'h00;
            endcase
            cur_last = (work_pos_reg == FB_CRC_HI);
        end else if (has_word_reg) begin
            cur_kind  = KIND_WORD;
            cur_value = word_val_reg;
            cur_index = word_idx_reg;
            cur_last  = !has_stat_reg;
        end else begin
            cur_kind   = KIND_STATUS;
            cur_status = stat_reg;
            cur_last   = 1'b1;
        end
    end

    // Output register takes a result whenever it is empty or being drained
    assign out_load = work_valid_reg && (!m_valid_reg || m_tready);
    // Next item may enter as the current one hands over its final result
    assign s_tready = !work_valid_reg || (out_load && cur_last);
    assign accept   = s_tvalid && s_tready;

    // Response parser: state update and results of one byte
    always_comb begin
        req_count_next  = req_count_reg;
        byte_pos_next   = byte_pos_reg;
        func_seen_next  = func_seen_reg;
        decl_count_next = decl_count_reg;
        pend_high_next  = pend_high_reg;
        words_next      = words_reg;
        rsp_word        = 1'b0;
        rsp_end         = 1'b0;
        rsp_value       = {pend_high_reg, in_byte};
        rsp_status      = ST_ACCEPTED;
        pos_cmp         = '0;
        need_cmp        = '0;
        if (accept) begin
            if (in_op == OP_REQUEST) begin
                req_count_next = in_count;
                byte_pos_next  = '0;
                words_next     = 7'd0;
            end else begin
                if (byte_pos_reg < MAX_POS) begin
                    if (byte_pos_reg == POS_W'(1)) begin
                        func_seen_next = in_byte;
                    end else if (byte_pos_reg == POS_W'(2)) begin
                        decl_count_next = in_byte;
                    end else if (byte_pos_reg != POS_W'(0)) begin
                        // odd offsets carry the high byte of a word
                        if (byte_pos_reg[0]) begin
                            pend_high_next = in_byte;
                        end else if (words_reg < req_count_reg) begin
                            rsp_word   = 1'b1;
                            words_next = words_reg + 7'd1;
                        end
                    end
                    byte_pos_next = byte_pos_reg + POS_W'(1);
                end
                if (s_tlast) begin
                    rsp_end  = 1'b1;
                    pos_cmp  = CMP_W'(byte_pos_next);
                    need_cmp = CMP_W'(MIN_RESP_BYTES) + CMP_W'(decl_count_next);
                    if (pos_cmp < CMP_W'(MIN_RESP_BYTES)) begin
                        rsp_status = ST_TOO_SHORT;
                    end else if (func_seen_next != FUNC_READ_HOLDING) begin
                        rsp_status = ST_BAD_FUNCTION;
                    end else if (pos_cmp < need_cmp) begin
                        rsp_status = ST_SHORT_DATA;
                    end else begin
                        rsp_status = ST_ACCEPTED;
                    end
                    byte_pos_next = '0;
                    words_next    = 7'd0;
                end
            end
        end
    end

    // Work register: load, step, retire
    always_comb begin
        work_valid_next = work_valid_reg;
        work_op_next    = work_op_reg;
        work_pos_next   = work_pos_reg;
        crc_next        = crc_reg;
        work_slave_next = work_slave_reg;
        work_addr_next  = work_addr_reg;
        work_cnt_next   = work_cnt_reg;
        has_word_next   = has_word_reg;
        has_stat_next   = has_stat_reg;
        word_val_next   = word_val_reg;
        word_idx_next   = word_idx_reg;
        stat_next       = stat_reg;

        if (out_load) begin
            if (cur_last) begin
                work_valid_next = 1'b0;
            end else if (work_op_reg == OP_REQUEST) begin
                work_pos_next = frame_pos_t'(work_pos_reg + 3'd1);
                if (work_pos_reg != FB_CRC_LO) begin
                    crc_next = crc_byte(crc_reg, cur_frame);
                end
            end else begin
                has_word_next = 1'b0;
            end
        end

        if (accept) begin
            if (in_op == OP_REQUEST) begin
                work_valid_next = 1'b1;
                work_op_next    = OP_REQUEST;
                work_pos_next   = FB_SLAVE;
                crc_next        = CRC_INIT;
                work_slave_next = in_slave;
                work_addr_next  = in_addr;
                work_cnt_next   = in_count;
            end else if (rsp_word || rsp_end) begin
                work_valid_next = 1'b1;
                work_op_next    = OP_RESPONSE;
                has_word_next   = rsp_word;
                has_stat_next   = rsp_end;
                word_val_next   = rsp_value;
                word_idx_next   = words_reg;
                stat_next       = rsp_status;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, cur_status, cur_index, cur_value, cur_frame};
            m_kind_next  = cur_kind;
            m_last_next  = cur_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_count_reg  <= 7'd0;
            byte_pos_reg   <= '0;
            func_seen_reg  <= 8'h00;
            decl_count_reg <= 8'h00;
            pend_high_reg  <= 8'h00;
            words_reg      <= 7'd0;
            work_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            req_count_reg  <= req_count_next;
            byte_pos_reg   <= byte_pos_next;
            func_seen_reg  <= func_seen_next;
            decl_count_reg <= decl_count_next;
            pend_high_reg  <= pend_high_next;
            words_reg      <= words_next;
            work_valid_reg <= work_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        work_op_reg    <= work_op_next;
        work_pos_reg   <= work_pos_next;
        crc_reg        <= crc_next;
        work_slave_reg <= work_slave_next;
        work_addr_reg  <= work_addr_next;
        work_cnt_reg   <= work_cnt_next;
        has_word_reg   <= has_word_next;
        has_stat_reg   <= has_stat_next;
        word_val_reg   <= word_val_next;
        word_idx_reg   <= word_idx_next;
        stat_reg       <= stat_next;
        m_data_reg     <= m_data_next;
        m_kind_reg     <= m_kind_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hdl/mrhm_checker.sv */
// ----------------------------------------------------------------------------
// mrhm_assert
// Port-level checks for the read-holding master, bound to the core module.
// ----------------------------------------------------------------------------
module mrhm_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mrhm_pkg::*;

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // a status always closes the item's results
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status not marked last");

    // frame bytes carry no word or status bits
    a_frame_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FRAME |-> m_tdata[39:8] == 32'd0)
        else $error("frame byte with stray fields");

endmodule

bind modbus_read_holding_master_core mrhm_assert u_mrhm_assert (.*);

/* tb/mrhm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrhm_checker
// Watches both channels of the read-holding master, predicts every result
// from the accepted input transfers and compares field by field.
// ----------------------------------------------------------------------------
module mrhm_checker #(
    parameter int unsigned MAX_RESPONSE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pend_count
);
    import mrhm_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [7:0]  frame_byte;
        logic [15:0] reg_value;
        logic [6:0]  reg_index;
        status_t     status;
        logic        last;
    } master_out_t;

    master_out_t due_results[$];

    // parser and request state
    logic [6:0] req_count;
    logic [8:0] rx_pos;
    logic [7:0] func_seen;
    logic [7:0] decl_bytes;
    logic [7:0] high_byte;
    logic [6:0] words_out;

    initial begin
        fail_count = 0;
        pend_count = 0;
    end

    // reflected CRC-16, feedback taken bit by bit from the data LSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            r = {1'b0, r[15:1]} ^ ((r[0] ^ b[k]) ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic push_result(input kind_t kind, input logic [7:0] fbyte,
                               input logic [15:0] value, input logic [6:0] index,
                               input status_t st, input logic last);
        master_out_t r;
        r.kind       = kind;
        r.frame_byte = fbyte;
        r.reg_value  = value;
        r.reg_index  = index;
        r.status     = st;
        r.last       = last;
        due_results = {due_results, r};
    endtask

    task automatic emit_request_frame(input logic [7:0] slave, input logic [15:0] addr,
                                      input logic [6:0] cnt);
        logic [7:0]  fb [8];
        logic [15:0] crc;
        fb[FB_SLAVE]   = slave;
        fb[FB_FUNC]    = FUNC_READ_HOLDING;
        fb[FB_ADDR_HI] = addr[15:8];
        fb[FB_ADDR_LO] = addr[7:0];
        fb[FB_CNT_HI]  = 8'h00;
        fb[FB_CNT_LO]  = {1'b0, cnt};
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc16_step(crc, fb[i]);
        end
        fb[FB_CRC_LO] = crc[7:0];
        fb[FB_CRC_HI] = crc[15:8];
        for (int i = 0; i < 8; i++) begin
            push_result(KIND_FRAME, fb[i], 16'h0000, 7'd0, ST_ACCEPTED, i == 7);
        end
        req_count = cnt;
        rx_pos    = '0;
        words_out = '0;
    endtask

    task automatic parse_response_byte(input logic [7:0] b, input logic is_end);
        status_t st;
        // bytes beyond the buffer are dropped, but an end mark still counts
        if (rx_pos < MAX_RESPONSE_BYTES) begin
            if (rx_pos == 1) begin
                func_seen = b;
            end else if (rx_pos == 2) begin
                decl_bytes = b;
            end else if (rx_pos >= 3) begin
                if (rx_pos[0]) begin
                    high_byte = b;
                end else if (words_out < req_count) begin
                    push_result(KIND_WORD, 8'h00, {high_byte, b}, words_out,
                                ST_ACCEPTED, !is_end);
                    words_out++;
                end
            end
            rx_pos++;
        end
        if (is_end) begin
            if (rx_pos < MIN_RESP_BYTES) begin
                st = ST_TOO_SHORT;
            end else if (func_seen != FUNC_READ_HOLDING) begin
                st = ST_BAD_FUNCTION;
            end else if (rx_pos < MIN_RESP_BYTES + decl_bytes) begin
                st = ST_SHORT_DATA;
            end else begin
                st = ST_ACCEPTED;
            end
            push_result(KIND_STATUS, 8'h00, 16'h0000, 7'd0, st, 1'b1);
            rx_pos    = '0;
            words_out = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        master_out_t want;
        if (due_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none got kind %0d tdata %h last %b",
                     $time, m_tuser, m_tdata, m_tlast);
        end else begin
            want = due_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(m_tuser));
            check_field("frame_byte", 16'(want.frame_byte), 16'(m_tdata[7:0]));
            check_field("register_value", want.reg_value, m_tdata[23:8]);
            check_field("register_index", 16'(want.reg_index), 16'(m_tdata[30:24]));
            check_field("status", 16'(want.status), 16'(m_tdata[32:31]));
            check_field("last", 16'(want.last), 16'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            req_count  = '0;
            rx_pos     = '0;
            func_seen  = '0;
            decl_bytes = '0;
            high_byte  = '0;
            words_out  = '0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser[0]) == OP_REQUEST) begin
                    emit_request_frame(s_tdata[7:0], s_tdata[23:8], s_tdata[30:24]);
                end else begin
                    parse_response_byte(s_tdata[38:31], s_tlast);
                end
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        pend_count = due_results.size();
    end

endmodule

/* tb/tb_modbus_read_holding_master_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_read_holding_master_core
// Stimulus for the read-holding master: directed frames for the edge cases,
// then random request/response exchanges with sender gaps and sink stalls.
// Checking is done by mrhm_checker alongside the core.
// ----------------------------------------------------------------------------
module tb_modbus_read_holding_master_core;
    import mrhm_pkg::*;

    localparam int unsigned MAX_RESP     = 256;
    localparam int          RANDOM_ITEMS = 330;
    localparam int          IDLE_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int          SETTLE       = 24;    // quiet cycles before the verdict

    // response shapes; the good one is weighted up in the random part
    typedef enum logic [2:0] {
        SHAPE_GOOD,
        SHAPE_BAD_FUNC,
        SHAPE_TRUNC,
        SHAPE_ODD,
        SHAPE_EXTRA,
        SHAPE_DECL
    } shape_t;

    // sink stall behaviour, changed every so often
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_LONG
    } rdy_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pend_count;

    int         burst_left = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;
    logic [7:0] rx_frame[$];

    rdy_mode_t  rdy_mode = RDY_ALWAYS;
    int         rdy_mode_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    modbus_read_holding_master_core #(
        .MAX_RESPONSE_BYTES(MAX_RESP)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    mrhm_checker #(
        .MAX_RESPONSE_BYTES(MAX_RESP)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pend_count(pend_count)
    );

    // Sink: a stall mode is held for a while, then another is picked
    always @(posedge aclk) begin
        if (rdy_mode_left == 0) begin
            rdy_mode      <= rdy_mode_t'($urandom_range(0, 3));
            rdy_mode_left <= $urandom_range(16, 160);
        end else begin
            rdy_mode_left <= rdy_mode_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            RDY_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RDY_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                // long runs of stall and of ready
                if ($urandom_range(0, 19) == 0) begin
                    m_tready <= ~m_tready;
                end
            end
        endcase
    end

    // Watchdog: any transfer on either side restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_modbus_read_holding_master_core: FAIL");
            $finish;
        end
    end

    // One input transfer; a new burst starts after a random gap
    task automatic send_item(input op_t op, input logic [7:0] slave,
                             input logic [15:0] addr, input logic [6:0] cnt,
                             input logic [7:0] rbyte, input logic rend);
        int   gap;
        logic rdy;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, rbyte, cnt, addr, slave};
        s_tlast  <= rend;
        // tready only moves just after an edge, so the falling edge sees
        // the value the next rising edge will use
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        items_sent++;
    endtask

    // Response fields are don't-care on a request, so fill them randomly
    task automatic send_request(input logic [7:0] slave, input logic [15:0] addr,
                                input logic [6:0] cnt);
        send_item(OP_REQUEST, slave, addr, cnt, 8'($urandom), 1'($urandom));
    endtask

    // Sends rx_frame byte by byte, end mark on the final byte
    task automatic send_response();
        for (int i = 0; i < rx_frame.size(); i++) begin
            send_item(OP_RESPONSE, 8'($urandom), 16'($urandom), 7'($urandom_range(0, 125)),
                      rx_frame[i], i == rx_frame.size() - 1);
        end
    endtask

    // Hold off the sender until every outstanding result has moved
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pend_count != 0);
        @(posedge aclk);
    endtask

    task automatic build_response(input shape_t shape, input int cnt, input logic [7:0] slave);
        int         decl;
        int         ndata;
        int         keep;
        logic [7:0] func;
        decl  = 2 * cnt;
        ndata = 2 * cnt;
        func  = FUNC_READ_HOLDING;
        case (shape)
            SHAPE_BAD_FUNC: begin
                do func = 8'($urandom); while (func == FUNC_READ_HOLDING);
            end
            SHAPE_ODD: begin
                ndata = 2 * cnt + 1;
            end
            SHAPE_EXTRA: begin
                ndata = 2 * cnt + 2 * $urandom_range(1, 3);
            end
            SHAPE_DECL: begin
                decl = $urandom_range(0, 255);
            end
            default: begin
            end
        endcase
        rx_frame = {slave, func, 8'(decl)};
        repeat (ndata + 2) rx_frame = {rx_frame, 8'($urandom)};  // data, then an unchecked CRC
        if (shape == SHAPE_TRUNC) begin
            keep = $urandom_range(1, rx_frame.size() - 1);
            while (rx_frame.size() > keep) void'(rx_frame.pop_back());
        end
    endtask

    initial begin
        int         stop_at;
        int         pick;
        int         cnt;
        bit         overlong_done;
        logic [7:0] slave;

        overlong_done = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // response before any request: count is zero, two bytes only
        rx_frame = {8'h01, 8'h03};
        send_response();
        // field extremes on requests
        send_request(8'h00, 16'h0000, 7'd0);
        send_request(8'hFF, 16'hFFFF, 7'd125);
        send_request(8'h11, 16'h006B, 7'd2);
        // good reply plus one word past the requested count
        rx_frame = {8'h11, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34};
        send_response();
        // exception-style reply, function code not 3
        rx_frame = {8'h11, 8'h83, 8'h02, 8'h00, 8'h01};
        send_response();
        // short of the declared byte count, odd trailing byte
        send_request(8'h5A, 16'h8000, 7'd3);
        rx_frame = {8'h5A, 8'h03, 8'h06, 8'h12, 8'h34, 8'h56};
        send_response();
        drain_results();

        // --- random ---
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (!overlong_done && items_sent > stop_at - RANDOM_ITEMS + 40) begin
                // largest request, reply runs past the response buffer so the
                // end mark lands on a dropped byte
                send_request(8'($urandom), 16'($urandom), 7'd125);
                build_response(SHAPE_GOOD, 125, 8'($urandom));
                repeat (5) rx_frame = {rx_frame, 8'($urandom)};
                send_response();
                overlong_done = 1'b1;
            end else if (pick < 8) begin
                // line noise: stray bytes with random end marks
                repeat ($urandom_range(1, 6)) begin
                    send_item(OP_RESPONSE, 8'($urandom), 16'($urandom),
                              7'($urandom_range(0, 125)), 8'($urandom),
                              $urandom_range(0, 3) == 0);
                end
            end else if (pick < 16) begin
                send_request(8'($urandom), 16'($urandom), 7'($urandom_range(0, 125)));
            end else begin
                cnt   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 125)
                                                     : $urandom_range(0, 8);
                slave = 8'($urandom);
                send_request(slave, 16'($urandom), 7'(cnt));
                pick = $urandom_range(0, 9);
                build_response((pick < 5) ? SHAPE_GOOD : shape_t'(pick - 4), cnt, slave);
                send_response();
                if ($urandom_range(0, 9) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pend_count == 0) begin
            $display("tb_modbus_read_holding_master_core: PASS");
        end else begin
            $display("tb_modbus_read_holding_master_core: FAIL");
        end
        $finish;
    end

endmodule
